// ----- design/cscf_pkg.sv -----
// Shared types and constants for the channel switch crossfader.
package cscf_pkg;

  // Default sizing of the block.
  localparam int NUM_CHANNELS_DEF = 4;
  localparam int SAMPLE_BITS_DEF  = 32;

  // Fixed field widths.
  localparam int OPCODE_W  = 1;
  localparam int CH_IDX_W  = 2;
  localparam int SEL_W     = 4;
  localparam int ALPHA_W   = 17;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 1;

  // Q16 alpha and gain constants.
  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'h10000;
  localparam logic [CFG_W-1:0]   GAIN_RESET = 17'd4811;

  // Input opcodes.
  localparam logic [OPCODE_W-1:0] OP_SAMPLE = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_TICK   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SELECTED_CHANNEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_GAIN        = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_MIX,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic step;
    logic mix;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ----- design/cscf_chan_if.sv -----
// Input and output stream interfaces of the channel switch crossfader.
interface cscf_in_if #(
  parameter int SAMPLE_BITS = cscf_pkg::SAMPLE_BITS_DEF
);
  import cscf_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [OPCODE_W-1:0]           opcode;
  logic [CH_IDX_W-1:0]           channel_index;
  logic signed [SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, output opcode, output channel_index, output sample_value,
                  input ready);
  modport sink (input valid, input opcode, input channel_index, input sample_value,
                output ready);
endinterface

interface cscf_out_if #(
  parameter int SAMPLE_BITS = cscf_pkg::SAMPLE_BITS_DEF
);
  import cscf_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mixed_value;
  logic [ALPHA_W-1:0]            fade_alpha;
  logic [CH_IDX_W-1:0]           active_channel;

  modport source (output valid, output mixed_value, output fade_alpha, output active_channel,
                  input ready);
  modport sink (input valid, input mixed_value, input fade_alpha, input active_channel,
                output ready);
endinterface

// ----- design/cscf_ctrl.sv -----
// Sequencing controller of the channel switch crossfader.
module cscf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cscf_pkg::sts_t sts_i,
  output cscf_pkg::cmd_t cmd_o
);
  import cscf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_STEP;
      end
      ST_STEP:   state_d = ST_MIX;
      ST_MIX:    state_d = ST_FINISH;
      ST_FINISH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_STEP:   cmd_o.step = 1'b1;
      ST_MIX:    cmd_o.mix = 1'b1;
      ST_FINISH: cmd_o.finish = sts_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- design/cscf_datapath.sv -----
// Datapath of the channel switch crossfader: sample store, resolution, alpha and mix.
module cscf_datapath #(
  parameter int NUM_CHANNELS = cscf_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = cscf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cscf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cscf_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  cscf_pkg::cmd_t                    cmd_i,
  output cscf_pkg::sts_t                    sts_o,
  input  logic [cscf_pkg::OPCODE_W-1:0]     in_opcode_i,
  input  logic [cscf_pkg::CH_IDX_W-1:0]     in_channel_index_i,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     out_mixed_value_o,
  output logic [cscf_pkg::ALPHA_W-1:0]      out_fade_alpha_o,
  output logic [cscf_pkg::CH_IDX_W-1:0]     out_active_channel_o
);
  import cscf_pkg::*;

  localparam int CH_W   = $clog2(NUM_CHANNELS);
  localparam int PROD_W = 2 * ALPHA_W;
  localparam int MIXP_W = SAMPLE_BITS + ALPHA_W + 2;

  // Configuration registers.
  logic [SEL_W-1:0] sel_q;
  logic [CFG_W-1:0] gain_cfg_q;

  // Architectural state.
  logic signed [SAMPLE_BITS-1:0] sample_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]       has_q;
  logic [CH_W-1:0]               res_idx_q;
  logic                          res_valid_q;
  logic                          ticked_q;
  logic signed [SAMPLE_BITS-1:0] fade_start_q;
  logic [ALPHA_W-1:0]            alpha_q;
  logic signed [SAMPLE_BITS-1:0] prev_out_q;

  // Working registers of one item.
  logic signed [SAMPLE_BITS-1:0] target_q;
  logic [PROD_W-1:0]             prod_q;
  logic signed [SAMPLE_BITS:0]   diff_q;
  logic signed [MIXP_W-1:0]      mixp_q;

  // Output register.
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_mixed_q;
  logic [ALPHA_W-1:0]            out_alpha_q;
  logic [CH_IDX_W-1:0]           out_chan_q;

  // Accept-cycle logic.
  logic                          wr_en;
  logic signed [SAMPLE_BITS-1:0] sample_n [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]       has_n;
  logic [CH_W-1:0]               desired;
  logic                          change;
  logic                          first;
  logic signed [SAMPLE_BITS-1:0] fs_res;
  logic [ALPHA_W-1:0]            alpha_res;
  logic signed [SAMPLE_BITS-1:0] target_d;
  logic [CFG_W-1:0]              gain_eff;
  logic [ALPHA_W-1:0]            rest;
  logic [PROD_W-1:0]             prod_d;

  // Step and finish logic.
  logic [ALPHA_W:0]              delta;
  logic [ALPHA_W:0]              alpha_sum;
  logic [ALPHA_W-1:0]            alpha_step;
  logic signed [SAMPLE_BITS:0]   diff_d;
  logic signed [MIXP_W-1:0]      mixp_d;
  logic signed [SAMPLE_BITS+2:0] result_w;
  logic signed [SAMPLE_BITS-1:0] result;

  assign wr_en = cmd_i.accept && (in_opcode_i == OP_SAMPLE)
                 && (32'(in_channel_index_i) < NUM_CHANNELS);

  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (wr_en && (32'(in_channel_index_i) == k)) begin
        sample_n[k] = in_sample_value_i;
        has_n[k]    = 1'b1;
      end else begin
        sample_n[k] = sample_q[k];
        has_n[k]    = has_q[k];
      end
    end
  end

  always_comb begin
    if (32'(sel_q) < NUM_CHANNELS) begin
      desired = sel_q[CH_W-1:0];
    end else if (res_valid_q) begin
      desired = res_idx_q;
    end else begin
      desired = '0;
    end
    change = !res_valid_q || (desired != res_idx_q);
    first  = !res_valid_q && !ticked_q;
    if (!change) begin
      fs_res    = fade_start_q;
      alpha_res = alpha_q;
    end else if (first) begin
      fs_res    = has_n[desired] ? sample_n[desired] : '0;
      alpha_res = ALPHA_ONE;
    end else begin
      fs_res    = prev_out_q;
      alpha_res = '0;
    end
    target_d = has_n[desired] ? sample_n[desired] : fs_res;
    if (gain_cfg_q >= ALPHA_ONE) begin
      gain_eff = ALPHA_ONE;
    end else begin
      gain_eff = ticked_q ? gain_cfg_q : '0;
    end
    rest   = ALPHA_ONE - alpha_res;
    prod_d = PROD_W'(gain_eff) * PROD_W'(rest);
  end

  always_comb begin
    delta      = (ALPHA_W + 1)'((prod_q + PROD_W'(16'hFFFF)) >> 16);
    alpha_sum  = {1'b0, alpha_q} + delta;
    alpha_step = (alpha_sum > {1'b0, ALPHA_ONE}) ? ALPHA_ONE : alpha_sum[ALPHA_W-1:0];
    diff_d     = (SAMPLE_BITS + 1)'(target_q) - (SAMPLE_BITS + 1)'(fade_start_q);
    mixp_d     = MIXP_W'(diff_q) * MIXP_W'($signed({1'b0, alpha_q}));
    result_w   = (SAMPLE_BITS + 3)'(fade_start_q) + $signed(mixp_q[MIXP_W-1:16]);
    result     = result_w[SAMPLE_BITS-1:0];
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q      <= '0;
      gain_cfg_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SELECTED_CHANNEL: sel_q <= cfg_wdata_i[SEL_W-1:0];
        REG_FADE_GAIN:        gain_cfg_q <= cfg_wdata_i;
        default:              sel_q <= sel_q;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_q        <= '0;
      res_idx_q    <= '0;
      res_valid_q  <= 1'b0;
      ticked_q     <= 1'b0;
      fade_start_q <= '0;
      alpha_q      <= ALPHA_ONE;
      prev_out_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        has_q        <= has_n;
        res_idx_q    <= desired;
        res_valid_q  <= 1'b1;
        ticked_q     <= 1'b1;
        fade_start_q <= fs_res;
        alpha_q      <= alpha_res;
      end
      if (cmd_i.step) begin
        alpha_q <= alpha_step;
      end
      if (cmd_i.finish) begin
        prev_out_q <= result;
        if (alpha_q == ALPHA_ONE) fade_start_q <= target_q;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        sample_q[k] <= sample_n[k];
      end
      target_q <= target_d;
      prod_q   <= prod_d;
    end
    if (cmd_i.step) begin
      diff_q <= diff_d;
    end
    if (cmd_i.mix) begin
      mixp_q <= mixp_d;
    end
    if (cmd_i.finish) begin
      out_mixed_q <= result;
      out_alpha_q <= alpha_q;
      out_chan_q  <= CH_IDX_W'(res_idx_q);
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_mixed_value_o    = out_mixed_q;
  assign out_fade_alpha_o     = out_alpha_q;
  assign out_active_channel_o = out_chan_q;

`ifndef SYNTHESIS
  a_alpha_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alpha_q <= ALPHA_ONE)
    else $error("alpha exceeds one");

  a_ticked_resolved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ticked_q |-> res_valid_q)
    else $error("ticked without a resolved channel");

  a_finish_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("finished item did not reach the output register");
`endif

endmodule

// ----- design/channel_switch_crossfader.sv -----
// Top level of the channel switch crossfader.
//
// Every input transfer is one tick: with opcode 0 it first stores sample_value as the last
// sample of channel channel_index, with opcode 1 it only advances time. Each tick gives exactly
// one output transfer carrying the crossfaded sample, the Q16 fade progress and the resolved
// channel. The active channel follows the selected_channel register; a selection at or above the
// channel count keeps the previous channel (channel 0 before anything was resolved). A channel
// change freezes the previous output as the fade start and restarts alpha at 0, after which alpha
// approaches 65536 by fade_gain (Q16) each tick; a gain of 65536 or more switches at once and a
// gain of 0 holds the fade. The very first tick resolves at full alpha and adds no fade step.
// Sequencing: each item passes through four steps, accept, alpha step, mix and finish. Its result
// is loaded into the output register in the finish step, and the next input transfer is taken
// only after that, so the block does not take a new item before it is through with the last. The
// sequence is set by the two dependent multiplications (the alpha step and the mix) that share one
// sequential datapath. The output register lets the next input transfer be taken while a
// finished result waits; if that result is still not taken when the next item finishes, the
// block holds in its finish cycle until it is. Configuration writes should be made only while
// no item is in flight.
module channel_switch_crossfader #(
  parameter int NUM_CHANNELS = cscf_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = cscf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cscf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cscf_pkg::CFG_W-1:0]     cfg_wdata_i,
  cscf_in_if.sink                        in_ch,
  cscf_out_if.source                     out_ch
);
  import cscf_pkg::*;

  // Command and status between the controller and the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller walks each item through accept, alpha step, mix and finish.
  cscf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the channel samples, the fade state and the output register.
  cscf_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .in_opcode_i          (in_ch.opcode),
    .in_channel_index_i   (in_ch.channel_index),
    .in_sample_value_i    (in_ch.sample_value),
    .out_valid_o          (out_ch.valid),
    .out_ready_i          (out_ch.ready),
    .out_mixed_value_o    (out_ch.mixed_value),
    .out_fade_alpha_o     (out_ch.fade_alpha),
    .out_active_channel_o (out_ch.active_channel)
  );

endmodule

// ----- tb/sv/tb_channel_switch_crossfader.sv -----
// Self-checking testbench for the channel switch crossfader: directed and random ticks.
module tb_channel_switch_crossfader;
  import cscf_pkg::*;

  localparam int NUM_CH       = NUM_CHANNELS_DEF;
  localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
  // An item passes through accept, alpha step, mix and finish before its result is registered.
  localparam int ITEM_CYCLES  = 4;
  localparam int RANDOM_TICKS = 500;
  // Longest legal quiet stretch is the forced receiver hold plus a register write.
  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 80;

  // One input tick as it crosses the input channel.
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [CH_IDX_W-1:0] channel;
    logic [SAMPLE_W-1:0] sample;
  } tick_t;

  // One output transfer: the mixed sample, fade progress and resolved channel.
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [ALPHA_W-1:0]  alpha;
    logic [CH_IDX_W-1:0] channel;
  } mix_out_t;

  // Keeps its own copy of the channel store, the fade state and both registers, predicts
  // the output of every accepted tick and compares output transfers in order.
  class crossfade_scoreboard;
    logic [SEL_W-1:0]           sel_reg;
    logic [CFG_W-1:0]           gain_reg;
    logic signed [SAMPLE_W-1:0] last_sample [NUM_CH];
    bit                         has_sample [NUM_CH];
    int unsigned                active_idx;
    bit                         active_valid;
    longint                     fade_from;
    longint                     prev_out;
    int unsigned                alpha;
    bit                         ticked;
    mix_out_t                   expected_mix_q [$];
    int                         errors;
    int                         ticks;
    int                         results;
    int                         switches;

    function new();
      sel_reg  = '0;
      gain_reg = GAIN_RESET;
      foreach (last_sample[i]) begin
        last_sample[i] = '0;
        has_sample[i]  = 1'b0;
      end
      active_idx   = 0;
      active_valid = 1'b0;
      fade_from    = 0;
      prev_out     = 0;
      alpha        = 32'(ALPHA_ONE);
      ticked       = 1'b0;
      errors       = 0;
      ticks        = 0;
      results      = 0;
      switches     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_SELECTED_CHANNEL) begin
        sel_reg = data[SEL_W-1:0];
      end else begin
        gain_reg = data;
      end
    endfunction

    function int expected_count();
      return expected_mix_q.size();
    endfunction

    function void note_tick(tick_t t);
      int unsigned     gain;
      int unsigned     wanted;
      longint          target;
      longint          mixed;
      longint unsigned step;
      mix_out_t        exp_out;
      ticks++;
      if (t.opcode == OP_SAMPLE) begin
        last_sample[t.channel] = t.sample;
        has_sample[t.channel]  = 1'b1;
      end
      gain = 32'((gain_reg > ALPHA_ONE) ? ALPHA_ONE : gain_reg);
      // The very first tick does not advance the fade unless the switch is instant.
      if (!ticked && gain < ALPHA_ONE) gain = 0;
      // A selection beyond the channel count keeps whatever was resolved before.
      if (sel_reg < NUM_CH) begin
        wanted = 32'(sel_reg);
      end else begin
        wanted = active_valid ? active_idx : 0;
      end
      if (!active_valid || wanted != active_idx) begin
        if (!active_valid && !ticked) begin
          fade_from = has_sample[wanted] ? longint'(last_sample[wanted]) : 0;
          alpha     = 32'(ALPHA_ONE);
        end else begin
          fade_from = prev_out;
          alpha     = 0;
          switches++;
        end
        active_idx   = wanted;
        active_valid = 1'b1;
      end
      target = has_sample[active_idx] ? longint'(last_sample[active_idx]) : fade_from;
      if (gain >= ALPHA_ONE) begin
        alpha = 32'(ALPHA_ONE);
      end else if (gain > 0 && alpha < ALPHA_ONE) begin
        // Rounded up, so any nonzero gain eventually completes the fade.
        step  = (longint'(gain) * longint'(ALPHA_ONE - alpha) + 64'd65535) >> 16;
        alpha = alpha + int'(step);
        if (alpha > ALPHA_ONE) alpha = 32'(ALPHA_ONE);
      end
      if (alpha >= ALPHA_ONE) begin
        mixed     = target;
        fade_from = target;
      end else begin
        mixed = fade_from + (((target - fade_from) * longint'(alpha)) >>> 16);
      end
      prev_out = mixed;
      ticked   = 1'b1;
      exp_out.value   = mixed[SAMPLE_W-1:0];
      exp_out.alpha   = alpha[ALPHA_W-1:0];
      exp_out.channel = active_idx[CH_IDX_W-1:0];
      expected_mix_q.push_back(exp_out);
    endfunction

    function void check_result(mix_out_t got);
      mix_out_t want;
      if (expected_mix_q.size() == 0) begin
        $error("output transfer with no tick waiting: mixed_value %0d", $signed(got.value));
        errors++;
        return;
      end
      want = expected_mix_q.pop_front();
      results++;
      if (got.value !== want.value) begin
        $error("mixed_value: expected %0d, got %0d", $signed(want.value), $signed(got.value));
        errors++;
      end
      if (got.alpha !== want.alpha) begin
        $error("fade_alpha: expected %0d, got %0d", want.alpha, got.alpha);
        errors++;
      end
      if (got.channel !== want.channel) begin
        $error("active_channel: expected %0d, got %0d", want.channel, got.channel);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  cscf_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
  cscf_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_ch ();

  crossfade_scoreboard sb = new();

  // Idling controls shared by the driving processes, in percent per cycle.
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  // Set by the stimulus to make the receiver hold off for that many cycles.
  int hold_request  = 0;
  int reg_writes    = 0;
  int idle_cycles   = 0;

  channel_switch_crossfader #(
    .NUM_CHANNELS(NUM_CH),
    .SAMPLE_BITS (SAMPLE_W)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offers one tick, with random idle cycles before it, and returns at the edge of its
  // transfer. Valid is left high so that back-to-back ticks need no second assignment in
  // the same time step; whoever stops sending lowers it.
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= t.opcode;
    in_ch.channel_index <= t.channel;
    in_ch.sample_value  <= t.sample;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_tick(t);
  endtask

  // Stops sending and waits until every predicted output has been taken, then lets the
  // block settle for the length of one item.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.expected_count() != 0) @(posedge clk_i);
    repeat (ITEM_CYCLES) @(posedge clk_i);
  endtask

  // Register writes are only made with the block idle, so the predictor can apply them at
  // once.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
    reg_writes++;
  endtask

  function automatic tick_t make_tick(logic [OPCODE_W-1:0] op, logic [CH_IDX_W-1:0] ch,
                                      logic [SAMPLE_W-1:0] val);
    tick_t t;
    t.opcode  = op;
    t.channel = ch;
    t.sample  = val;
    return t;
  endfunction

  // Samples lean toward the extremes and small values, where rounding of the mix shows.
  function automatic tick_t rand_tick();
    tick_t t;
    t.opcode  = ($urandom_range(9) < 6) ? OP_SAMPLE : OP_TICK;
    t.channel = CH_IDX_W'($urandom_range(NUM_CH - 1));
    case ($urandom_range(9))
      0:       t.sample = {1'b0, {(SAMPLE_W - 1){1'b1}}};
      1:       t.sample = {1'b1, {(SAMPLE_W - 1){1'b0}}};
      2:       t.sample = '0;
      3:       t.sample = '1;
      4, 5:    t.sample = SAMPLE_W'($urandom_range(2000)) - SAMPLE_W'(1000);
      default: t.sample = $urandom();
    endcase
    return t;
  endfunction

  function automatic logic [CFG_W-1:0] rand_gain();
    case ($urandom_range(7))
      0:       return '0;
      1:       return CFG_W'(1);
      2:       return CFG_W'(65535);
      3:       return ALPHA_ONE;
      4:       return '1;
      5:       return CFG_W'($urandom_range(131071));
      default: return CFG_W'($urandom_range(40000, 1000));
    endcase
  endfunction

  // Receiver: takes output transfers, checks them and decides ready for the next cycle.
  // Payload and handshake are read right after the edge, so they hold the values that
  // the edge sampled.
  initial begin : result_sink
    int       hold_left;
    mix_out_t got;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got.value   = out_ch.mixed_value;
        got.alpha   = out_ch.fade_alpha;
        got.channel = out_ch.active_channel;
        sb.check_result(got);
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Ends the run if no transfer happens on either channel for too long.
  initial begin : stall_watchdog
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $error("no transfer for %0d cycles, %0d results still expected", STALL_LIMIT,
           sb.expected_count());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int random_sent;
    int phase;
    int n;
    random_sent = 0;
    phase       = 0;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= REG_SELECTED_CHANNEL;
    cfg_wdata_i         <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.opcode        <= OP_TICK;
    in_ch.channel_index <= '0;
    in_ch.sample_value  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling, reset register values at first.
    // The first tick resolves channel 0 at full alpha and takes its fresh sample.
    send_tick(make_tick(OP_SAMPLE, 2'd0, 32'h7FFF_FFFF));
    send_tick(make_tick(OP_SAMPLE, 2'd1, 32'h8000_0000));
    send_tick(make_tick(OP_SAMPLE, 2'd3, 32'h0000_0000));
    // A bare tick must ignore its payload.
    send_tick(make_tick(OP_TICK, 2'd2, 32'hFFFF_FFFF));
    // Switch from the largest to the smallest sample at the reset gain.
    set_reg(REG_SELECTED_CHANNEL, CFG_W'(1));
    send_tick(make_tick(OP_TICK, 2'd0, 32'h0));
    send_tick(make_tick(OP_TICK, 2'd1, 32'h0));
    send_tick(make_tick(OP_TICK, 2'd3, 32'h0));
    // Channel 2 has never been written, so its target is the frozen fade start.
    set_reg(REG_SELECTED_CHANNEL, CFG_W'(2));
    send_tick(make_tick(OP_TICK, 2'd0, 32'h0));
    send_tick(make_tick(OP_SAMPLE, 2'd2, 32'hFFFF_FFFF));
    // An out-of-range selection keeps channel 2.
    set_reg(REG_SELECTED_CHANNEL, CFG_W'(9));
    send_tick(make_tick(OP_TICK, 2'd0, 32'h0));
    // Zero gain holds alpha at zero after a switch.
    set_reg(REG_FADE_GAIN, '0);
    set_reg(REG_SELECTED_CHANNEL, CFG_W'(3));
    send_tick(make_tick(OP_TICK, 2'd0, 32'h0));
    send_tick(make_tick(OP_SAMPLE, 2'd3, 32'd12345));
    // Full gain completes at once; a gain above full counts as full.
    set_reg(REG_FADE_GAIN, ALPHA_ONE);
    send_tick(make_tick(OP_TICK, 2'd0, 32'h0));
    set_reg(REG_FADE_GAIN, '1);
    set_reg(REG_SELECTED_CHANNEL, CFG_W'(0));
    send_tick(make_tick(OP_SAMPLE, 2'd0, 32'h0));
    // The smallest gain still moves alpha by one step of rounding up.
    set_reg(REG_FADE_GAIN, CFG_W'(1));
    set_reg(REG_SELECTED_CHANNEL, CFG_W'(1));
    send_tick(make_tick(OP_TICK, 2'd0, 32'h0));
    send_tick(make_tick(OP_SAMPLE, 2'd1, 32'h5555_AAAA));
    // Just below full gain.
    set_reg(REG_FADE_GAIN, CFG_W'(65535));
    set_reg(REG_SELECTED_CHANNEL, CFG_W'(15));
    send_tick(make_tick(OP_SAMPLE, 2'd1, 32'hAAAA_5555));
    set_reg(REG_SELECTED_CHANNEL, CFG_W'(2));
    send_tick(make_tick(OP_TICK, 2'd0, 32'h0));
    send_tick(make_tick(OP_TICK, 2'd0, 32'h0));

    // Random part: short phases, each with a new selection and often a new gain, so that
    // channel switches are frequent. The idling pattern rotates with the phase.
    while (random_sent < RANDOM_TICKS) begin
      case (phase % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 51; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 51; end
        default: begin src_idle_pct = 23; snk_stall_pct = 23; end
      endcase
      if ($urandom_range(9) < 7) begin
        set_reg(REG_SELECTED_CHANNEL, CFG_W'($urandom_range(NUM_CH - 1)));
      end else begin
        set_reg(REG_SELECTED_CHANNEL, CFG_W'($urandom_range(15, NUM_CH)));
      end
      if ($urandom_range(1) == 1) set_reg(REG_FADE_GAIN, rand_gain());
      n = (phase == 4) ? 24 : $urandom_range(20, 8);
      // Once the receiver holds off for a long time while ticks keep coming, so the
      // output register fills and the input stalls.
      if (phase == 4) hold_request = LONG_HOLD;
      for (int i = 0; i < n; i++) begin
        // Once the sender pauses mid-phase until every output has been taken.
        if (phase == 5 && i == n / 2) wait_idle();
        send_tick(rand_tick());
        random_sent++;
      end
      phase++;
    end

    wait_idle();
    repeat (2 * ITEM_CYCLES) @(posedge clk_i);

    $display("Sent %0d ticks (%0d random in %0d phases) with %0d register writes.",
             sb.ticks, random_sent, phase, reg_writes);
    $display("Checked %0d outputs across %0d channel switches, %0d mismatches.",
             sb.results, sb.switches, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
